/* src/b10kd_pkg.sv */
// Shared types, codes and group placement helpers for the base-10000
// decimal to scaled 128-bit integer converter. No dependencies.
package b10kd_pkg;

  localparam int RESULT_BITS_DEF = 128;

  localparam logic [15:0] GROUP_BASE = 16'd10000;

  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_DIGIT  = 2'd1;
  localparam logic [1:0] OP_NULL   = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_NAN   = 2'd1;
  localparam logic [1:0] ERR_DIGIT = 2'd2;
  localparam logic [1:0] ERR_OVF   = 2'd3;

  // Scale step applied by one group: full group or a truncated one.
  typedef enum logic [1:0] {
    MS_10000,
    MS_1000,
    MS_100,
    MS_10
  } msel_e;

  typedef struct packed {
    logic  counts;    // group takes part in the value
    logic  in_range;  // position lies at or below the last needed group
    msel_e msel;
  } place_t;

  typedef struct packed {
    logic        clr;
    logic        start;
    logic [13:0] mult;
    logic [13:0] addend;
  } mac_ctrl_t;

  typedef struct packed {
    logic done;
    logic overflow;
    logic zero;
  } mac_stat_t;

  // Decide how the group at position pos contributes, given the first
  // group's weight and the number of fraction digits kept.
  function automatic place_t group_place(input logic [15:0]        pos,
                                         input logic signed [15:0] weight,
                                         input logic [5:0]         scale);
    logic signed [17:0] diff;
    logic signed [17:0] k;
    logic [4:0]         span;
    logic signed [7:0]  rem;
    place_t             p;
    diff = $signed({2'b00, pos}) - 18'(weight);
    span = 5'((7'(scale) + 7'd3) >> 2);
    k    = diff - 18'sd1;
    rem  = $signed({2'b00, scale}) - $signed({2'b00, k[3:0], 2'b00});
    p.in_range = (diff <= $signed({13'd0, span}));
    p.counts   = 1'b0;
    p.msel     = MS_10000;
    if (diff <= 18'sd0) begin
      p.counts = 1'b1;
    end else if (k <= 18'sd15) begin
      if (rem >= 8'sd4) begin
        p.counts = 1'b1;
      end else if (rem == 8'sd3) begin
        p.counts = 1'b1;
        p.msel   = MS_1000;
      end else if (rem == 8'sd2) begin
        p.counts = 1'b1;
        p.msel   = MS_100;
      end else if (rem == 8'sd1) begin
        p.counts = 1'b1;
        p.msel   = MS_10;
      end
    end
    return p;
  endfunction

  function automatic logic [13:0] group_mult(input msel_e msel);
    logic [13:0] m;
    unique case (msel)
      MS_10000: m = 14'd10000;
      MS_1000:  m = 14'd1000;
      MS_100:   m = 14'd100;
      MS_10:    m = 14'd10;
      default:  m = 14'd10000;
    endcase
    return m;
  endfunction

  // Truncated group value; divide by 10, 100 or 1000 through a reciprocal
  // multiply that is exact for every group below 10000.
  function automatic logic [13:0] group_addend(input logic [15:0] dig,
                                               input msel_e       msel);
    logic [15:0] recip;
    logic [4:0]  shamt;
    logic [31:0] prod;
    unique case (msel)
      MS_1000: begin
        recip = 16'd52429;
        shamt = 5'd19;
      end
      MS_100: begin
        recip = 16'd5243;
        shamt = 5'd19;
      end
      MS_10: begin
        recip = 16'd8389;
        shamt = 5'd23;
      end
      default: begin
        recip = 16'd0;
        shamt = 5'd0;
      end
    endcase
    prod = 32'(dig) * 32'(recip);
    if (msel == MS_10000) begin
      return dig[13:0];
    end
    return 14'(prod >> shamt);
  endfunction

endpackage

/* src/b10kd_if.sv */
// Handshake channels of the decimal converter: input item and result beat.
// Standalone; used by the top level and its environment.
interface b10kd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] group_weight;
  logic [15:0]        sign_word;
  logic [14:0]        group_count;
  logic [15:0]        digit_group;

  modport source (output valid, opcode, group_weight, sign_word, group_count,
                  digit_group, input ready);
  modport sink (input valid, opcode, group_weight, sign_word, group_count,
                digit_group, output ready);
endinterface

interface b10kd_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        value_low;
  logic signed [63:0] value_high;
  logic               is_null;
  logic [1:0]         error_code;

  modport source (output valid, value_low, value_high, is_null, error_code,
                  input ready);
  modport sink (input valid, value_low, value_high, is_null, error_code,
                output ready);
endinterface

/* src/b10kd_mac.sv */
// Limb-serial multiply-accumulate: acc = acc * mult + addend, 32 bits a cycle.
// Depends on b10kd_pkg for the control and status structs.
module b10kd_mac import b10kd_pkg::*; #(
  parameter int  RESULT_BITS = RESULT_BITS_DEF,
  localparam int AccW        = ((RESULT_BITS + 31) / 32) * 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mac_ctrl_t       ctrl_i,
  output mac_stat_t       stat_o,
  output logic [AccW-1:0] acc_o
);

  localparam int Limbs = AccW / 32;
  localparam int StepW = $clog2(Limbs);

  logic [AccW-1:0]  acc_q;
  logic [AccW-1:0]  acc_d;
  logic [13:0]      carry_q;
  logic [13:0]      mult_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic [45:0]      prod;
  logic             last;

  assign prod  = 46'(acc_q[31:0]) * 46'(mult_q) + 46'(carry_q);
  // rotate: the new low limb lands on top, so after all limbs acc is in place
  assign acc_d = {prod[31:0], acc_q[AccW-1:32]};
  assign last  = (step_q == StepW'(Limbs - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      carry_q <= '0;
      mult_q  <= '0;
      step_q  <= '0;
      busy_q  <= 1'b0;
    end else if (ctrl_i.clr) begin
      acc_q  <= '0;
      busy_q <= 1'b0;
    end else if (ctrl_i.start) begin
      busy_q  <= 1'b1;
      step_q  <= '0;
      mult_q  <= ctrl_i.mult;
      carry_q <= ctrl_i.addend;
    end else if (busy_q) begin
      acc_q   <= acc_d;
      carry_q <= prod[45:32];
      step_q  <= step_q + StepW'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign stat_o.done     = busy_q && last;
  assign stat_o.overflow = (prod[45:32] != 14'd0) || (acc_d[AccW-1:RESULT_BITS-1] != '0);
  assign stat_o.zero     = (acc_q == '0);
  assign acc_o           = acc_q;

endmodule

/* src/base10000_numeric_to_decimal128.sv */
// Top level of the base-10000 decimal to scaled 128-bit integer converter.
// Depends on b10kd_pkg, b10kd_if and b10kd_mac.
//
//   channel   dir  handshake      payload
//   cfg       in   cfg_we_i       cfg_data_i (fraction digits)
//   in_i      in   valid/ready    opcode, group_weight, sign_word,
//                                 group_count, digit_group
//   out_o     out  valid/ready    value_low, value_high, is_null, error_code
//
// A header, a skipped digit group or an ignored item is taken in ST_IDLE. A
// digit group that counts starts the 32-bit limb multiplier in b10kd_mac and
// waits in ST_MAC until every limb is done. After the last group each padding
// group passes ST_PAD and ST_MAC, then ST_PAD and ST_RESULT close and load
// the result. in_i.ready is high only while the sequencer is idle. A waiting
// result beat does not stall input; only a new result waits for the output
// register. Reset is asynchronous, active low, and clears the scale to zero.
module base10000_numeric_to_decimal128 import b10kd_pkg::*; #(
  parameter int RESULT_BITS = RESULT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_data_i,
  b10kd_in_if.sink    in_i,
  b10kd_out_if.source out_o
);

  localparam int AccW = ((RESULT_BITS + 31) / 32) * 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_PAD,
    ST_RESULT
  } state_e;

  state_e             state_q;
  logic [5:0]         fd_q;
  logic [15:0]        gp_q;
  logic [14:0]        gl_q;
  logic signed [15:0] sw_q;
  logic               neg_q;
  logic [1:0]         err_q;
  logic               null_q;
  logic               out_valid_q;
  logic [63:0]        out_low_q;
  logic [63:0]        out_high_q;
  logic               out_null_q;
  logic [1:0]         out_err_q;

  mac_ctrl_t       mac_ctrl;
  mac_stat_t       mac_stat;
  logic [AccW-1:0] acc;
  place_t          place;
  logic            take;
  logic            dig_ok;
  logic            dig_go;
  logic            pad_go;
  logic            out_free;
  logic            load_res;
  logic [127:0]    mag;
  logic [127:0]    res_val;

  b10kd_mac #(
    .RESULT_BITS (RESULT_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .stat_o (mac_stat),
    .acc_o  (acc)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign take       = in_i.valid && in_i.ready;
  assign place      = group_place(gp_q, sw_q, fd_q);
  assign dig_ok     = (in_i.digit_group < GROUP_BASE);
  assign out_free   = !out_valid_q || out_o.ready;
  assign load_res   = (state_q == ST_RESULT) && out_free;

  assign dig_go = take && (in_i.opcode == OP_DIGIT) && (gl_q != 15'd0) &&
                  (err_q == ERR_NONE) && place.counts && dig_ok;
  assign pad_go = (state_q == ST_PAD) && (err_q == ERR_NONE) && !mac_stat.zero &&
                  place.in_range;

  always_comb begin
    mac_ctrl        = '0;
    mac_ctrl.clr    = take && (in_i.opcode == OP_HEADER);
    mac_ctrl.start  = dig_go || pad_go;
    mac_ctrl.mult   = group_mult(place.msel);
    mac_ctrl.addend = dig_go ? group_addend(in_i.digit_group, place.msel) : 14'd0;
  end

  assign mag     = 128'(acc);
  assign res_val = (null_q || (err_q != ERR_NONE)) ? 128'd0 :
                   neg_q ? (~mag + 128'd1) : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fd_q        <= '0;
      gp_q        <= '0;
      gl_q        <= '0;
      sw_q        <= '0;
      neg_q       <= 1'b0;
      err_q       <= ERR_NONE;
      null_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_low_q   <= '0;
      out_high_q  <= '0;
      out_null_q  <= 1'b0;
      out_err_q   <= ERR_NONE;
    end else begin
      if (cfg_we_i) begin
        fd_q <= cfg_data_i;
      end
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            case (in_i.opcode)
              OP_HEADER: begin
                sw_q  <= in_i.group_weight;
                neg_q <= in_i.sign_word[14];
                err_q <= (in_i.sign_word[15:14] == 2'b11) ? ERR_NAN : ERR_NONE;
                gp_q  <= '0;
                gl_q  <= in_i.group_count;
                if (in_i.group_count == 15'd0) begin
                  state_q <= ST_PAD;
                end
              end
              OP_DIGIT: begin
                if (gl_q != 15'd0) begin
                  gp_q <= gp_q + 16'd1;
                  gl_q <= gl_q - 15'd1;
                  if ((err_q == ERR_NONE) && place.counts && !dig_ok) begin
                    err_q <= ERR_DIGIT;
                  end
                  if (dig_go) begin
                    state_q <= ST_MAC;
                  end else if (gl_q == 15'd1) begin
                    state_q <= ST_PAD;
                  end
                end
              end
              OP_NULL: begin
                gl_q    <= '0;
                null_q  <= 1'b1;
                state_q <= ST_RESULT;
              end
              default: ;
            endcase
          end
        end
        ST_MAC: begin
          if (mac_stat.done) begin
            if (mac_stat.overflow) begin
              err_q <= ERR_OVF;
            end
            state_q <= (gl_q == 15'd0) ? ST_PAD : ST_IDLE;
          end
        end
        ST_PAD: begin
          // pad missing low groups with zero until scale is covered, unless acc is zero or an error is set
          if (pad_go) begin
            gp_q    <= gp_q + 16'd1;
            state_q <= ST_MAC;
          end else begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          // hold until the output register is free
          if (load_res) begin
            out_low_q   <= res_val[63:0];
            out_high_q  <= res_val[127:64];
            out_null_q  <= null_q;
            out_err_q   <= null_q ? ERR_NONE : err_q;
            null_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.value_low  = out_low_q;
  assign out_o.value_high = $signed(out_high_q);
  assign out_o.is_null    = out_null_q;
  assign out_o.error_code = out_err_q;

endmodule
